[design/traffic_light_with_button_override_assert.svh]
// Assertion macros used by the traffic light controller.
`ifndef TRAFFIC_LIGHT_WITH_BUTTON_OVERRIDE_ASSERT_SVH
`define TRAFFIC_LIGHT_WITH_BUTTON_OVERRIDE_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled during rst.
`define TLBO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk and disabled during rst.
`define TLBO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/tlbo_pkg.sv]
// Shared types, constants and helper functions of the traffic light controller.
package tlbo_pkg;

  localparam int CFG_BITS       = 16;
  localparam int ELAPSED_BITS   = 17;
  localparam int CFG_INDEX_BITS = 3;
  localparam int COUNT_OUT_BITS = 16;

  localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

  // Light phase, also the encoding of the light_phase output.
  typedef enum logic [1:0] {
    PH_GREEN  = 2'd0,
    PH_YELLOW = 2'd1,
    PH_RED    = 2'd2,
    PH_SAFE   = 2'd3
  } phase_t;

  // Configuration register indexes.
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  localparam cfg_index_t REG_GREEN      = 3'd0;
  localparam cfg_index_t REG_YELLOW     = 3'd1;
  localparam cfg_index_t REG_RED        = 3'd2;
  localparam cfg_index_t REG_BLINK      = 3'd3;
  localparam cfg_index_t REG_LONG_PRESS = 3'd4;
  localparam cfg_index_t REG_DEBOUNCE   = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [CFG_BITS-1:0] RST_GREEN      = 16'd5000;
  localparam logic [CFG_BITS-1:0] RST_YELLOW     = 16'd2000;
  localparam logic [CFG_BITS-1:0] RST_RED        = 16'd5000;
  localparam logic [CFG_BITS-1:0] RST_BLINK      = 16'd500;
  localparam logic [CFG_BITS-1:0] RST_LONG_PRESS = 16'd3000;
  localparam logic [CFG_BITS-1:0] RST_DEBOUNCE   = 16'd200;

  typedef struct packed {
    logic [CFG_BITS-1:0] green_ms;
    logic [CFG_BITS-1:0] yellow_ms;
    logic [CFG_BITS-1:0] red_ms;
    logic [CFG_BITS-1:0] blink_ms;
    logic [CFG_BITS-1:0] long_press_ms;
    logic [CFG_BITS-1:0] short_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic green;
    logic yellow;
    logic red;
  } lamps_t;

  // One result word as produced by the core.
  typedef struct packed {
    lamps_t                    lamps;
    phase_t                    phase;
    logic [COUNT_OUT_BITS-1:0] completed;
  } word_t;

  // Normal phase sequence; safe mode never leaves.
  function automatic phase_t next_phase(phase_t p);
    phase_t n;
    case (p)
      PH_GREEN:  n = PH_YELLOW;
      PH_YELLOW: n = PH_RED;
      PH_RED:    n = PH_GREEN;
      default:   n = PH_SAFE;
    endcase
    return n;
  endfunction

  // Saturating increment of an elapsed-time counter.
  function automatic logic [ELAPSED_BITS-1:0] sat_inc(logic [ELAPSED_BITS-1:0] v);
    return (v == ELAPSED_MAX) ? v : v + 1'b1;
  endfunction

endpackage

[design/tlbo_if.sv]
// Valid/ready channel interfaces for the tick words and the lamp words.
interface tlbo_tick_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink (input valid, input button_level, output ready);
endinterface

interface tlbo_lamp_if;
  logic        valid;
  logic        ready;
  logic        lamp_green;
  logic        lamp_yellow;
  logic        lamp_red;
  logic [1:0]  light_phase;
  logic [15:0] completed_cycles;

  modport source (output valid, output lamp_green, output lamp_yellow, output lamp_red,
                  output light_phase, output completed_cycles, input ready);
  modport sink (input valid, input lamp_green, input lamp_yellow, input lamp_red,
                input light_phase, input completed_cycles, output ready);
endinterface

[design/traffic_light_with_button_override.sv]
// Traffic light controller with push-button override.
//
// Usage: one word on tick_in per millisecond tick carries the sampled button
// level (1 released, 0 pressed). For every accepted tick exactly one word
// leaves on light_out with the lamp drives, the light phase and the count of
// completed red-to-green cycles. Durations and press timing are set through
// the write port (wr_en, wr_index, wr_data) while the block is idle.
// The result word of a tick is valid on light_out in the cycle after it is
// accepted. Throughput: one tick per cycle unless light_out stalls; the state
// update is a single pass of counters and comparators ahead of the output
// register. When the receiver stalls, the output register holds its word and
// tick_in is stalled in the same cycle, so no word is lost or repeated.
// Reset (rst, synchronous) returns the lights to green with all timers and
// the cycle count at zero and all registers at their default durations; the
// block accepts ticks in the first cycle after reset.
`include "traffic_light_with_button_override_assert.svh"

module traffic_light_with_button_override #(
  parameter int CYCLE_COUNT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [tlbo_pkg::CFG_INDEX_BITS-1:0] wr_index,
  input  logic [tlbo_pkg::CFG_BITS-1:0]       wr_data,
  tlbo_tick_if.sink                           tick_in,
  tlbo_lamp_if.source                         light_out
);
  import tlbo_pkg::*;

  cfg_t   cfg;
  word_t  word;
  word_t  out_word;
  phase_t state_phase;
  logic   out_valid;
  logic   accept;

  tlbo_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  tlbo_core #(
    .CYCLE_COUNT_BITS (CYCLE_COUNT_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .step        (accept),
    .button      (tick_in.button_level),
    .word        (word),
    .state_phase (state_phase)
  );

  // Take a tick whenever the output register is empty or being drained.
  assign tick_in.ready = !out_valid || light_out.ready;
  assign accept        = tick_in.valid && tick_in.ready;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (light_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word <= word;
    end
  end

  assign light_out.valid            = out_valid;
  assign light_out.lamp_green       = out_word.lamps.green;
  assign light_out.lamp_yellow      = out_word.lamps.yellow;
  assign light_out.lamp_red         = out_word.lamps.red;
  assign light_out.light_phase      = out_word.phase;
  assign light_out.completed_cycles = out_word.completed;

  // Safe mode is left only through reset.
  `TLBO_ASSERT_NEXT(a_safe_sticky, state_phase == PH_SAFE, state_phase == PH_SAFE, "safe mode left without reset")

  // Outside safe mode exactly one lamp is lit.
  `TLBO_ASSERT_NOW(a_one_lamp, out_valid && (out_word.phase != PH_SAFE), $onehot({out_word.lamps.green, out_word.lamps.yellow, out_word.lamps.red}), "lamps disagree with phase")

  // A stalled output word blocks new ticks.
  `TLBO_ASSERT_NOW(a_stall_blocks, out_valid && !light_out.ready, !accept, "tick taken while output stalled")

endmodule

[design/tlbo_cfg_regs.sv]
// Configuration register file of the traffic light controller.
module tlbo_cfg_regs (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [tlbo_pkg::CFG_INDEX_BITS-1:0]   wr_index,
  input  logic [tlbo_pkg::CFG_BITS-1:0]         wr_data,
  output tlbo_pkg::cfg_t                        cfg
);
  import tlbo_pkg::*;

  // Decode the write; indexes past the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.green_ms      <= RST_GREEN;
      cfg.yellow_ms     <= RST_YELLOW;
      cfg.red_ms        <= RST_RED;
      cfg.blink_ms      <= RST_BLINK;
      cfg.long_press_ms <= RST_LONG_PRESS;
      cfg.short_gap_ms  <= RST_DEBOUNCE;
    end else if (wr_en) begin
      case (wr_index)
        REG_GREEN:      cfg.green_ms      <= wr_data;
        REG_YELLOW:     cfg.yellow_ms     <= wr_data;
        REG_RED:        cfg.red_ms        <= wr_data;
        REG_BLINK:      cfg.blink_ms      <= wr_data;
        REG_LONG_PRESS: cfg.long_press_ms <= wr_data;
        REG_DEBOUNCE:   cfg.short_gap_ms  <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

[design/tlbo_core.sv]
// Light state machine, button timing and cycle counter, one tick per step.
module tlbo_core #(
  parameter int CYCLE_COUNT_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  tlbo_pkg::cfg_t  cfg,
  input  logic            step,
  input  logic            button,
  output tlbo_pkg::word_t word,
  output tlbo_pkg::phase_t state_phase
);
  import tlbo_pkg::*;

  localparam logic [ELAPSED_BITS-1:0] EL_ZERO = '0;

  // State registers.
  phase_t                    phase;
  logic [ELAPSED_BITS-1:0]   phase_elapsed;
  logic [ELAPSED_BITS-1:0]   press_elapsed;
  logic [ELAPSED_BITS-1:0]   since_short_press;
  logic [ELAPSED_BITS-1:0]   blink_elapsed;
  logic                      previous_button;
  logic                      hold_armed;
  logic                      blink_lamp_on;
  lamps_t                    lamp_regs;
  logic [CYCLE_COUNT_BITS-1:0] cycle_count;

  // Next values.
  phase_t                    phase_next;
  logic [ELAPSED_BITS-1:0]   phase_elapsed_next;
  logic [ELAPSED_BITS-1:0]   press_elapsed_next;
  logic [ELAPSED_BITS-1:0]   since_short_press_next;
  logic [ELAPSED_BITS-1:0]   blink_elapsed_next;
  logic                      hold_armed_next;
  logic                      blink_lamp_on_next;
  lamps_t                    lamp_regs_next;
  logic [CYCLE_COUNT_BITS-1:0] cycle_count_next;

  // Intermediate terms of one step.
  logic                      press_edge;
  logic                      release_edge;
  logic                      armed_eff;
  logic                      short_ok;
  logic                      long_hit;
  logic                      dur_hit;
  logic                      blink_hit;
  logic                      blink_on_eff;
  logic                      wrap_short;
  logic                      wrap_dur;
  phase_t                    ph_short;
  phase_t                    ph_long;
  logic [CFG_BITS-1:0]       dur;
  logic [ELAPSED_BITS-1:0]   press_el_eff;
  logic [ELAPSED_BITS-1:0]   phase_el_short;
  logic [ELAPSED_BITS-1:0]   blink_el_eff;

  // Next-state logic: button edges, short press, long press, phase timeout, blink.
  always_comb begin
    press_edge   = previous_button & ~button;
    release_edge = ~previous_button & button;
    press_el_eff = press_edge ? EL_ZERO : press_elapsed;
    armed_eff    = press_edge | hold_armed;

    // A short press advances the phase right away.
    short_ok = release_edge && armed_eff &&
               (press_el_eff < {1'b0, cfg.long_press_ms}) &&
               (since_short_press > {1'b0, cfg.short_gap_ms});
    ph_short       = short_ok ? next_phase(phase) : phase;
    phase_el_short = short_ok ? EL_ZERO : phase_elapsed;
    wrap_short     = short_ok && (phase == PH_RED);

    // Holding the button long enough enters safe mode for good.
    long_hit = armed_eff && !release_edge && !button &&
               (press_el_eff >= {1'b0, cfg.long_press_ms}) && (ph_short != PH_SAFE);
    ph_long      = long_hit ? PH_SAFE : ph_short;
    blink_el_eff = long_hit ? EL_ZERO : blink_elapsed;
    blink_on_eff = long_hit ? 1'b0 : blink_lamp_on;

    // Phase timeout.
    case (ph_long)
      PH_GREEN:  dur = cfg.green_ms;
      PH_YELLOW: dur = cfg.yellow_ms;
      PH_RED:    dur = cfg.red_ms;
      default:   dur = cfg.blink_ms;
    endcase
    dur_hit    = (ph_long != PH_SAFE) && (phase_el_short >= {1'b0, dur});
    phase_next = dur_hit ? next_phase(ph_long) : ph_long;
    wrap_dur   = dur_hit && (ph_long == PH_RED);

    // Safe-mode blink timer.
    blink_hit          = (ph_long == PH_SAFE) && (blink_el_eff >= {1'b0, cfg.blink_ms});
    blink_lamp_on_next = blink_hit ? ~blink_on_eff : blink_on_eff;

    hold_armed_next        = armed_eff && !release_edge && !long_hit;
    phase_elapsed_next     = sat_inc(dur_hit ? EL_ZERO : phase_el_short);
    press_elapsed_next     = sat_inc(press_el_eff);
    since_short_press_next = sat_inc(short_ok ? EL_ZERO : since_short_press);
    blink_elapsed_next     = sat_inc(blink_hit ? EL_ZERO : blink_el_eff);
    cycle_count_next       = cycle_count + CYCLE_COUNT_BITS'(wrap_short)
                                         + CYCLE_COUNT_BITS'(wrap_dur);
  end

  // Output logic: lamps follow the phase, or the blink in safe mode.
  always_comb begin
    if (phase_next != PH_SAFE) begin
      lamp_regs_next.green  = (phase_next == PH_GREEN);
      lamp_regs_next.yellow = (phase_next == PH_YELLOW);
      lamp_regs_next.red    = (phase_next == PH_RED);
    end else if (blink_hit) begin
      lamp_regs_next.green  = 1'b0;
      lamp_regs_next.yellow = blink_lamp_on_next;
      lamp_regs_next.red    = 1'b0;
    end else begin
      lamp_regs_next = lamp_regs;
    end
    word.lamps     = lamp_regs_next;
    word.phase     = phase_next;
    word.completed = COUNT_OUT_BITS'(cycle_count_next);
  end

  assign state_phase = phase;

  // State update on every accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_GREEN;
      phase_elapsed     <= '0;
      press_elapsed     <= '0;
      since_short_press <= '0;
      blink_elapsed     <= '0;
      previous_button   <= 1'b1;
      hold_armed        <= 1'b0;
      blink_lamp_on     <= 1'b0;
      lamp_regs         <= '0;
      cycle_count       <= '0;
    end else if (step) begin
      phase             <= phase_next;
      phase_elapsed     <= phase_elapsed_next;
      press_elapsed     <= press_elapsed_next;
      since_short_press <= since_short_press_next;
      blink_elapsed     <= blink_elapsed_next;
      previous_button   <= button;
      hold_armed        <= hold_armed_next;
      blink_lamp_on     <= blink_lamp_on_next;
      lamp_regs         <= lamp_regs_next;
      cycle_count       <= cycle_count_next;
    end
  end

endmodule

[verif/traffic_light_with_button_override_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the traffic light controller with button override.
module traffic_light_with_button_override_tb;
  import tlbo_pkg::*;

  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int MAX_REPORTS     = 10;
  localparam int IDLE_PCT        = 34;
  localparam int NORMAL_SEGMENTS = 12;
  localparam int NORMAL_ITEMS    = 110;
  localparam int SAFE_SEGMENTS   = 4;
  localparam int SAFE_ITEMS      = 90;
  localparam int PLAN_ROWS       = 33;
  localparam int NO_CAP          = 32'h7fff_ffff;

  // Indexes past the last register; writes to them must be dropped.
  localparam cfg_index_t REG_SPARE_LO = 3'd6;
  localparam cfg_index_t REG_SPARE_HI = 3'd7;
  localparam logic [CFG_BITS-1:0] DUR_MAX = '1;

  localparam word_t GREEN_AT_START = '{
    lamps: '{green: 1'b1, yellow: 1'b0, red: 1'b0}, phase: PH_GREEN, completed: '0};

  typedef struct packed {
    logic                is_write;
    cfg_index_t          index;
    logic [CFG_BITS-1:0] data;
    logic                button;
    logic                has_want;
    word_t               want;
  } plan_row_t;

  logic                clk;
  logic                rst;
  logic                wr_en;
  cfg_index_t          wr_index;
  logic [CFG_BITS-1:0] wr_data;

  tlbo_tick_if tick_ch ();
  tlbo_lamp_if lamp_ch ();

  traffic_light_with_button_override dut (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .tick_in   (tick_ch),
    .light_out (lamp_ch)
  );

  // Predictor state: registers, timers and lamps as the controller should hold them.
  cfg_t                      regs;
  phase_t                    ph;
  logic [ELAPSED_BITS-1:0]   t_phase, t_press, t_short, t_blink;
  logic                      btn_prev, armed, blink_on;
  lamps_t                    lamps;
  logic [COUNT_OUT_BITS-1:0] cycles;

  word_t lamp_expected [$];
  int    mismatches;
  int    steady;
  int    hold_reqs;
  int    low_cap;
  int    low_run;
  int    sent_items;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [ELAPSED_BITS-1:0] bump(logic [ELAPSED_BITS-1:0] v);
    return (v == {ELAPSED_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

  // Move to the next phase of the normal sequence; safe mode stays put.
  function automatic void phase_advance();
    t_phase = '0;
    case (ph)
      PH_GREEN:  ph = PH_YELLOW;
      PH_YELLOW: ph = PH_RED;
      PH_RED: begin
        ph     = PH_GREEN;
        cycles = cycles + 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Work out the lamp word for one tick and update the predictor state.
  function automatic word_t lamp_predict(logic btn);
    word_t                   w;
    logic [ELAPSED_BITS-1:0] dur;
    if (btn_prev && !btn) begin
      t_press = '0;
      armed   = 1'b1;
    end
    if (!btn_prev && btn) begin
      if (armed && t_press < {1'b0, regs.long_press_ms} &&
          t_short > {1'b0, regs.short_gap_ms}) begin
        phase_advance();
        t_short = '0;
      end
      armed = 1'b0;
    end
    if (armed && !btn && t_press >= {1'b0, regs.long_press_ms} && ph != PH_SAFE) begin
      ph       = PH_SAFE;
      armed    = 1'b0;
      blink_on = 1'b0;
      t_blink  = '0;
    end
    btn_prev = btn;
    if (ph != PH_SAFE) begin
      case (ph)
        PH_GREEN:  dur = {1'b0, regs.green_ms};
        PH_YELLOW: dur = {1'b0, regs.yellow_ms};
        default:   dur = {1'b0, regs.red_ms};
      endcase
      if (t_phase >= dur) phase_advance();
      lamps = '{green: ph == PH_GREEN, yellow: ph == PH_YELLOW, red: ph == PH_RED};
    end else if (t_blink >= {1'b0, regs.blink_ms}) begin
      blink_on = !blink_on;
      lamps    = '{green: 1'b0, yellow: blink_on, red: 1'b0};
      t_blink  = '0;
    end
    w.lamps     = lamps;
    w.phase     = ph;
    w.completed = cycles;
    t_phase = bump(t_phase);
    t_press = bump(t_press);
    t_short = bump(t_short);
    t_blink = bump(t_blink);
    return w;
  endfunction

  function automatic plan_row_t tick_row(logic b);
    return '{is_write: 1'b0, index: REG_GREEN, data: '0, button: b, has_want: 1'b0,
             want: '0};
  endfunction

  function automatic plan_row_t check_row(logic b, word_t w);
    return '{is_write: 1'b0, index: REG_GREEN, data: '0, button: b, has_want: 1'b1,
             want: w};
  endfunction

  function automatic plan_row_t reg_row(cfg_index_t idx, logic [CFG_BITS-1:0] d);
    return '{is_write: 1'b1, index: idx, data: d, button: 1'b1, has_want: 1'b0,
             want: '0};
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_duration();
    case ($urandom_range(15))
      0:       return DUR_MAX;
      1, 2:    return CFG_BITS'($urandom_range(0, 2));
      default: return CFG_BITS'($urandom_range(3, 40));
    endcase
  endfunction

  // Offer one tick word and record what it should produce once accepted.
  // Zero runs are cut at low_cap so that a hold never reaches safe mode early.
  task automatic send_tick(input logic b, input logic has_want = 1'b0,
                           input word_t want = '0);
    word_t guess;
    logic  level;
    level = b;
    if (!level && low_run >= low_cap) level = 1'b1;
    low_run = level ? 0 : low_run + 1;
    while (steady == 0 && $urandom_range(99) < IDLE_PCT) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid        <= 1'b1;
    tick_ch.button_level <= level;
    do @(posedge clk); while (!tick_ch.ready);
    guess = lamp_predict(level);
    lamp_expected.push_back(has_want ? want : guess);
    sent_items++;
  endtask

  task automatic wait_drain();
    tick_ch.valid <= 1'b0;
    while (lamp_expected.size() != 0) @(posedge clk);
  endtask

  // Write one register; out-of-range indexes leave the predictor alone.
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_BITS-1:0] d);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= d;
    @(posedge clk);
    case (idx)
      REG_GREEN:      regs.green_ms      = d;
      REG_YELLOW:     regs.yellow_ms     = d;
      REG_RED:        regs.red_ms        = d;
      REG_BLINK:      regs.blink_ms      = d;
      REG_LONG_PRESS: regs.long_press_ms = d;
      REG_DEBOUNCE:   regs.short_gap_ms  = d;
      default: ;
    endcase
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // A released gap, a press of len ticks, then the release.
  task automatic press_and_release(input int len);
    repeat ($urandom_range(0, 10)) send_tick(1'b1);
    repeat (len) send_tick(1'b0);
    send_tick(1'b1);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 10)) send_tick(1'($urandom_range(1)));
  endtask

  // Receiver: random ready, with one long hold-off per request.
  initial begin : receiver
    int hold_seen;
    hold_seen     = 0;
    lamp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen     = hold_reqs;
        lamp_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        lamp_ch.ready <= (steady != 0) || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Compare every result word with the oldest expectation.
  always @(posedge clk) begin : check_words
    word_t want;
    if (!rst && lamp_ch.valid && lamp_ch.ready) begin
      if (lamp_expected.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("ERROR: unexpected lamp word at %0t", $realtime);
        mismatches++;
      end else begin
        want = lamp_expected.pop_front();
        if (lamp_ch.lamp_green !== want.lamps.green ||
            lamp_ch.lamp_yellow !== want.lamps.yellow ||
            lamp_ch.lamp_red !== want.lamps.red ||
            lamp_ch.light_phase !== want.phase ||
            lamp_ch.completed_cycles !== want.completed) begin
          if (mismatches < MAX_REPORTS)
            $display("ERROR at %0t: want g%b y%b r%b ph %0d cnt %0d, got g%b y%b r%b ph %0d cnt %0d",
                     $realtime, want.lamps.green, want.lamps.yellow, want.lamps.red,
                     want.phase, want.completed, lamp_ch.lamp_green, lamp_ch.lamp_yellow,
                     lamp_ch.lamp_red, lamp_ch.light_phase, lamp_ch.completed_cycles);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run when no word moves for too long.
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (tick_ch.valid && tick_ch.ready) || (lamp_ch.valid && lamp_ch.ready)) begin
      quiet = 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet++;
    end
  end

  // Stimulus.
  initial begin : stimulus
    plan_row_t plan [PLAN_ROWS];
    int        target;
    int        len;
    int        seg;
    logic      held;
    logic      paused;

    rst                  = 1'b1;
    wr_en                = 1'b0;
    wr_index             = REG_GREEN;
    wr_data              = '0;
    tick_ch.valid        = 1'b0;
    tick_ch.button_level = 1'b1;
    mismatches           = 0;
    steady               = 0;
    hold_reqs            = 0;
    low_cap              = NO_CAP;
    low_run              = 0;
    sent_items           = 0;
    held                 = 1'b0;
    paused               = 1'b0;
    regs = '{green_ms: RST_GREEN, yellow_ms: RST_YELLOW, red_ms: RST_RED,
             blink_ms: RST_BLINK, long_press_ms: RST_LONG_PRESS, short_gap_ms: RST_DEBOUNCE};
    ph       = PH_GREEN;
    t_phase  = '0;
    t_press  = '0;
    t_short  = '0;
    t_blink  = '0;
    btn_prev = 1'b1;
    armed    = 1'b0;
    blink_on = 1'b0;
    lamps    = '0;
    cycles   = '0;

    // Directed part: reset state, early press, zero and maximum durations,
    // debounce extremes, press length at the long-press limit, spare indexes.
    plan = '{
      check_row(1'b1, GREEN_AT_START),
      check_row(1'b0, GREEN_AT_START),
      check_row(1'b1, GREEN_AT_START),
      reg_row(REG_GREEN, '0),
      reg_row(REG_YELLOW, '0),
      reg_row(REG_RED, '0),
      reg_row(REG_DEBOUNCE, '0),
      reg_row(REG_LONG_PRESS, DUR_MAX),
      reg_row(REG_BLINK, '0),
      reg_row(REG_SPARE_LO, 16'h0001),
      reg_row(REG_SPARE_HI, DUR_MAX),
      tick_row(1'b1), tick_row(1'b1), tick_row(1'b1), tick_row(1'b1),
      tick_row(1'b0), tick_row(1'b1),
      reg_row(REG_GREEN, DUR_MAX),
      reg_row(REG_YELLOW, DUR_MAX),
      reg_row(REG_RED, DUR_MAX),
      reg_row(REG_DEBOUNCE, DUR_MAX),
      tick_row(1'b1), tick_row(1'b0), tick_row(1'b1),
      reg_row(REG_DEBOUNCE, '0),
      tick_row(1'b0), tick_row(1'b0), tick_row(1'b1), tick_row(1'b0), tick_row(1'b1),
      reg_row(REG_LONG_PRESS, 16'd1),
      tick_row(1'b0), tick_row(1'b1)
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].is_write) begin
        wait_drain();
        write_reg(plan[i].index, plan[i].data);
      end else begin
        send_tick(plan[i].button, plan[i].has_want, plan[i].want);
      end
    end

    // Normal operation: presses stay at or below the long-press time.
    for (seg = 0; seg < NORMAL_SEGMENTS; seg++) begin
      wait_drain();
      steady = int'(seg == 3);
      write_reg(REG_GREEN, pick_duration());
      write_reg(REG_YELLOW, pick_duration());
      write_reg(REG_RED, pick_duration());
      write_reg(REG_BLINK, CFG_BITS'($urandom_range(0, 20)));
      write_reg(REG_LONG_PRESS, ($urandom_range(7) == 0) ? DUR_MAX :
                                CFG_BITS'($urandom_range(1, 25)));
      case ($urandom_range(9))
        0:          write_reg(REG_DEBOUNCE, DUR_MAX);
        1, 2, 3, 4: write_reg(REG_DEBOUNCE, '0);
        default:    write_reg(REG_DEBOUNCE, CFG_BITS'($urandom_range(1, 25)));
      endcase
      low_cap = int'(regs.long_press_ms);
      low_run = 0;
      target  = sent_items + NORMAL_ITEMS;
      while (sent_items < target) begin
        if (seg == 2 && !held && sent_items >= target - NORMAL_ITEMS / 2) begin
          hold_reqs++;
          held = 1'b1;
        end
        if (seg == 5 && !paused && sent_items >= target - NORMAL_ITEMS / 2) begin
          wait_drain();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 75) begin
          if (regs.long_press_ms <= 40) begin
            case ($urandom_range(2))
              0:       len = int'(regs.long_press_ms);
              1:       len = (regs.long_press_ms > 1) ? int'(regs.long_press_ms) - 1 : 1;
              default: len = int'($urandom_range(1, regs.long_press_ms));
            endcase
          end else begin
            len = int'($urandom_range(1, 20));
          end
          press_and_release(len);
        end else begin
          noise_burst();
        end
      end
      send_tick(1'b1);
    end
    steady = 0;

    // Safe mode: a hold past the long-press time enters it, then blink periods are swept.
    low_cap = NO_CAP;
    for (seg = 0; seg < SAFE_SEGMENTS; seg++) begin
      wait_drain();
      case (seg)
        0: begin
          write_reg(REG_GREEN, pick_duration());
          write_reg(REG_YELLOW, pick_duration());
          write_reg(REG_RED, pick_duration());
          write_reg(REG_DEBOUNCE, CFG_BITS'($urandom_range(0, 10)));
          write_reg(REG_LONG_PRESS, ($urandom_range(1) == 0) ? '0 :
                                    CFG_BITS'($urandom_range(1, 20)));
          write_reg(REG_BLINK, CFG_BITS'($urandom_range(1, 12)));
        end
        1:       write_reg(REG_BLINK, '0);
        2:       write_reg(REG_BLINK, DUR_MAX);
        default: write_reg(REG_BLINK, CFG_BITS'($urandom_range(1, 6)));
      endcase
      target = sent_items + SAFE_ITEMS;
      if (seg == 0) begin
        repeat (4) press_and_release($urandom_range(1, 3));
        send_tick(1'b1);
        repeat (regs.long_press_ms + 1) send_tick(1'b0);
        send_tick(1'b1);
      end
      while (sent_items < target) begin
        if ($urandom_range(99) < 75) press_and_release($urandom_range(1, 40));
        else noise_burst();
      end
      send_tick(1'b1);
    end

    wait_drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[traffic_light_with_button_override.f]
+incdir+design
design/tlbo_pkg.sv
design/tlbo_if.sv
design/tlbo_cfg_regs.sv
design/tlbo_core.sv
design/traffic_light_with_button_override.sv
verif/traffic_light_with_button_override_tb.sv
